>>> src/lph_pkg.sv
// Shared constants, codes and control types for the linear probe hash table.
package lph_pkg;

  localparam int TABLE_DEPTH = 1024;  // power of two: key mod depth is a mask
  localparam int SLOT_W      = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int DEF_WORKERS    = 4;
  localparam int DEF_MAX_PROBES = 1024;
  localparam int DEF_EVENT_BITS = 16;
  localparam int DEF_KEY_BITS   = 64;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_ERASE  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_WRITE  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_DISABLED = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  localparam logic [3:0] FLD_CYAN    = 4'd0;
  localparam logic [3:0] FLD_BLUE    = 4'd1;
  localparam logic [3:0] FLD_PINK    = 4'd2;
  localparam logic [3:0] FLD_RED     = 4'd3;
  localparam logic [3:0] FLD_PRED    = 4'd4;
  localparam logic [3:0] FLD_EVENT   = 4'd5;
  localparam logic [3:0] FLD_INDEX   = 4'd6;
  localparam logic [3:0] FLD_LOWLINK = 4'd7;
  localparam logic [3:0] FLD_LIVE    = 4'd8;

  localparam logic [2:0] REG_ATTR_ENABLE = 3'd0;
  localparam logic [8:0] ATTR_ENABLE_RST = 9'd3;

  typedef struct packed {
    logic clear_wr;  // write a zero row during the reset sweep
    logic load;      // capture the incoming transaction
    logic mem_rd;    // read the row at the current address
    logic advance;   // step the probe to the next slot
    logic finish;    // commit writes and load the result register
  } lph_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_insert;
    logic hit_used;
    logic key_match;
    logic probe_last;
    logic out_free;
  } lph_stat_t;

endpackage

>>> src/lph_ifs.sv
// Valid/ready channel interfaces for input items and results.
interface lph_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [63:0] hash_key;
  logic [1:0]  worker;
  logic [9:0]  slot;
  logic [3:0]  attr_select;
  logic [31:0] value;
  modport source (output valid, command, hash_key, worker, slot, attr_select, value,
                  input ready);
  modport sink (input valid, command, hash_key, worker, slot, attr_select, value,
                output ready);
endinterface

interface lph_result_if;
  logic        valid;
  logic        ready;
  logic        is_new;
  logic [9:0]  found_slot;
  logic [31:0] attr_value;
  logic [63:0] stored_key;
  logic        any_cyan;
  logic        occupied;
  logic [10:0] entry_count;
  logic [1:0]  status;
  modport source (output valid, is_new, found_slot, attr_value, stored_key, any_cyan,
                  occupied, entry_count, status, input ready);
  modport sink (input valid, is_new, found_slot, attr_value, stored_key, any_cyan,
                occupied, entry_count, status, output ready);
endinterface

>>> src/lph_ctrl.sv
// Controller state machine: clear sweep, accept, probe read and check.
module lph_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lph_pkg::lph_stat_t stat,
  output lph_pkg::lph_cmd_t  cmd
);
  import lph_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_CHECK = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   keep_probing;

  assign keep_probing = stat.is_insert && stat.hit_used && !stat.key_match &&
                        !stat.probe_last;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.mem_rd = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (keep_probing) begin
          cmd.advance = 1'b1;
          state_next  = S_READ;
        end else if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

endmodule

>>> src/lph_dpath.sv
// Datapath: slot memories, probe address, entry count and result register.
module lph_dpath #(
  parameter int WORKERS    = lph_pkg::DEF_WORKERS,
  parameter int MAX_PROBES = lph_pkg::DEF_MAX_PROBES,
  parameter int EVENT_BITS = lph_pkg::DEF_EVENT_BITS,
  parameter int KEY_BITS   = lph_pkg::DEF_KEY_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  lph_pkg::lph_cmd_t  cmd,
  output lph_pkg::lph_stat_t stat,
  input  logic [8:0]         attr_enable,
  input  logic [1:0]         command,
  input  logic [63:0]        hash_key,
  input  logic [1:0]         worker,
  input  logic [9:0]         slot,
  input  logic [3:0]         attr_select,
  input  logic [31:0]        value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               is_new,
  output logic [9:0]         found_slot,
  output logic [31:0]        attr_value,
  output logic [63:0]        stored_key,
  output logic               any_cyan,
  output logic               occupied,
  output logic [10:0]        entry_count,
  output logic [1:0]         status
);
  import lph_pkg::*;

  localparam int FL_W = 2 * WORKERS + 3;
  localparam int TR_W = SLOT_W + EVENT_BITS;
  localparam int PC_W = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
  localparam int BLUE = WORKERS;
  localparam int PINK = WORKERS + 1;
  localparam int RED  = 2 * WORKERS + 1;
  localparam int LIVE = 2 * WORKERS + 2;

  logic              mem_used  [TABLE_DEPTH];
  logic [FL_W-1:0]   mem_flag  [TABLE_DEPTH];
  logic [TR_W-1:0]   mem_trace [TABLE_DEPTH];
  logic [63:0]       mem_scc   [TABLE_DEPTH];
  logic [KEY_BITS-1:0] mem_key [TABLE_DEPTH];

  logic              rd_used;
  logic [FL_W-1:0]   rd_flag;
  logic [TR_W-1:0]   rd_trace;
  logic [63:0]       rd_scc;
  logic [KEY_BITS-1:0] rd_key;

  logic [1:0]          cmd_r;
  logic [KEY_BITS-1:0] key_r;
  logic [1:0]          worker_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [3:0]          attr_r;
  logic [31:0]         val_r;
  logic [SLOT_W-1:0]   pos;
  logic [PC_W-1:0]     pcnt;
  logic [SLOT_W-1:0]   clr_addr;
  logic [CNT_W-1:0]    count;

  logic [SLOT_W-1:0] cur_addr, wr_addr;
  logic              is_ins, ins_new, ins_full, erase_hit, en_ok, do_write;
  logic [WORKERS-1:0] wmask, ncyan, npink;
  logic [FL_W-1:0]   nf;
  logic [TR_W-1:0]   nt;
  logic [63:0]       ns;
  logic [31:0]       field;
  logic              row_we, row_zero, key_we;

  assign is_ins   = (cmd_r == CMD_INSERT);
  assign cur_addr = is_ins ? pos : slot_r;
  assign ins_new  = is_ins && !rd_used;
  assign ins_full = is_ins && rd_used && (rd_key != key_r);
  assign erase_hit = (cmd_r == CMD_ERASE) && rd_used;
  assign en_ok    = (attr_r <= FLD_LIVE) && ((attr_enable >> attr_r) & 9'd1) != 9'd0;
  assign do_write = (cmd_r == CMD_WRITE) && en_ok;
  assign wmask    = WORKERS'(1) << worker_r;  // zero for a worker out of range

  // Attribute update and readback of the updated row
  always_comb begin
    nf    = rd_flag;
    nt    = rd_trace;
    ns    = rd_scc;
    ncyan = rd_flag[WORKERS-1:0];
    npink = rd_flag[PINK +: WORKERS];
    if (do_write) begin
      unique case (attr_r)
        FLD_CYAN:    ncyan = (ncyan & ~wmask) | (val_r[0] ? wmask : '0);
        FLD_BLUE:    nf[BLUE] = val_r[0];
        FLD_PINK:    npink = (npink & ~wmask) | (val_r[0] ? wmask : '0);
        FLD_RED:     nf[RED] = val_r[0];
        FLD_PRED:    nt[SLOT_W-1:0] = val_r[SLOT_W-1:0];
        FLD_EVENT:   nt[TR_W-1:SLOT_W] = val_r[EVENT_BITS-1:0];
        FLD_INDEX:   ns[31:0] = val_r;
        FLD_LOWLINK: ns[63:32] = val_r;
        FLD_LIVE:    nf[LIVE] = val_r[0];
        default:     nf[LIVE] = rd_flag[LIVE];
      endcase
    end
    nf[WORKERS-1:0]     = ncyan;
    nf[PINK +: WORKERS] = npink;
    unique case (attr_r)
      FLD_CYAN:    field = 32'(|(ncyan & wmask));
      FLD_BLUE:    field = 32'(nf[BLUE]);
      FLD_PINK:    field = 32'(|(npink & wmask));
      FLD_RED:     field = 32'(nf[RED]);
      FLD_PRED:    field = 32'(nt[SLOT_W-1:0]);
      FLD_EVENT:   field = 32'(nt[TR_W-1:SLOT_W]);
      FLD_INDEX:   field = ns[31:0];
      FLD_LOWLINK: field = ns[63:32];
      FLD_LIVE:    field = 32'(nf[LIVE]);
      default:     field = '0;
    endcase
  end

  assign row_we   = cmd.clear_wr || (cmd.finish && (ins_new || erase_hit || do_write));
  assign row_zero = cmd.clear_wr || erase_hit;
  assign key_we   = cmd.finish && ins_new;
  assign wr_addr  = cmd.clear_wr ? clr_addr : cur_addr;

  always_ff @(posedge clk) begin
    if (row_we) begin
      mem_used[wr_addr]  <= row_zero ? 1'b0 : (rd_used | ins_new);
      mem_flag[wr_addr]  <= row_zero ? '0 : nf;
      mem_trace[wr_addr] <= row_zero ? '0 : nt;
      mem_scc[wr_addr]   <= row_zero ? '0 : ns;
    end
    if (cmd.mem_rd) begin
      rd_used  <= mem_used[cur_addr];
      rd_flag  <= mem_flag[cur_addr];
      rd_trace <= mem_trace[cur_addr];
      rd_scc   <= mem_scc[cur_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) mem_key[cur_addr] <= key_r;
    if (cmd.mem_rd) rd_key <= mem_key[cur_addr];
  end

  // Item capture and probe sequencing
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r    <= command;
      key_r    <= hash_key[KEY_BITS-1:0];
      worker_r <= worker;
      slot_r   <= SLOT_W'(slot);
      attr_r   <= attr_select;
      val_r    <= value;
      pos      <= SLOT_W'(hash_key[KEY_BITS-1:0]);
      pcnt     <= '0;
    end else if (cmd.advance) begin
      pos  <= pos + SLOT_W'(1);
      pcnt <= pcnt + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      count    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear_wr) clr_addr <= clr_addr + SLOT_W'(1);
      if (cmd.finish && ins_new) count <= count + CNT_W'(1);
      else if (cmd.finish && erase_hit) count <= count - CNT_W'(1);
      if (cmd.finish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Result register; ins_full here means the probe limit ran out
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      is_new     <= ins_new;
      found_slot <= ins_full ? '0 : 10'(cur_addr);
      attr_value <= (cmd_r[1] && en_ok) ? field : '0;
      stored_key <= ins_full ? '0 : 64'(ins_new ? key_r : rd_key);
      any_cyan   <= (ins_full || erase_hit) ? 1'b0 : |nf[WORKERS-1:0];
      occupied   <= ins_full ? 1'b0 : (is_ins ? 1'b1 :
                    ((cmd_r == CMD_ERASE) ? 1'b0 : rd_used));
      entry_count <= 11'(ins_new ? count + CNT_W'(1) :
                         (erase_hit ? count - CNT_W'(1) : count));
      if (ins_full)                          status <= ST_FULL;
      else if (cmd_r == CMD_ERASE && !rd_used) status <= ST_EMPTY;
      else if (cmd_r[1] && !en_ok)           status <= ST_DISABLED;
      else                                   status <= ST_OK;
    end
  end

  assign stat.clear_last = (clr_addr == SLOT_W'(TABLE_DEPTH - 1));
  assign stat.is_insert  = is_ins;
  assign stat.hit_used   = rd_used;
  assign stat.key_match  = (rd_key == key_r);
  assign stat.probe_last = (pcnt == PC_W'(MAX_PROBES - 1));
  assign stat.out_free   = !out_valid || out_ready;

endmodule

>>> src/linear_probe_hash_table.sv
// Top level of the linear probe hash table: config register and core wiring.
// Usage:
//  - in_ch carries one command transaction (insert, erase, attribute read or
//    write); out_ch returns exactly one result transaction per command.
//  - The APB port holds attr_enable at byte address 0; writes take effect at
//    the access cycle. The user must make them only while no command is in
//    flight; the block itself does not enforce this.
//  - After reset the block sweeps all 1024 slots, one per cycle, to empty
//    them and zero their attributes; in_ch.ready stays low during the sweep,
//    while APB writes are taken as usual.
//  - Erase and attribute access: after acceptance the slot is read, then
//    checked, and the result is registered; the next command follows from idle.
//  - Insert: each slot probed is one read of the slot memory and one compare;
//    the result is registered after the last probe, then the block returns to idle.
//  - A new command is accepted in the cycle after a result is registered,
//    even if out_ch is stalled; a command whose result is ready waits in the
//    check step until the held result is taken.
module linear_probe_hash_table #(
  parameter int WORKERS    = lph_pkg::DEF_WORKERS,
  parameter int MAX_PROBES = lph_pkg::DEF_MAX_PROBES,
  parameter int EVENT_BITS = lph_pkg::DEF_EVENT_BITS,
  parameter int KEY_BITS   = lph_pkg::DEF_KEY_BITS
) (
  input  logic         clk,
  input  logic         rst,
  lph_item_if.sink     in_ch,
  lph_result_if.source out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import lph_pkg::*;

  lph_cmd_t   cmd;
  lph_stat_t  stat;
  logic [8:0] attr_enable;

  // Config register: single write per access phase
  assign pready = 1'b1;
  assign prdata = (paddr == REG_ATTR_ENABLE) ? 32'(attr_enable) : '0;

  always_ff @(posedge clk) begin
    if (rst) attr_enable <= ATTR_ENABLE_RST;
    else if (psel && penable && pwrite && paddr == REG_ATTR_ENABLE)
      attr_enable <= pwdata[8:0];
  end

  lph_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lph_dpath #(
    .WORKERS    (WORKERS),
    .MAX_PROBES (MAX_PROBES),
    .EVENT_BITS (EVENT_BITS),
    .KEY_BITS   (KEY_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .attr_enable (attr_enable),
    .command     (in_ch.command),
    .hash_key    (in_ch.hash_key),
    .worker      (in_ch.worker),
    .slot        (in_ch.slot),
    .attr_select (in_ch.attr_select),
    .value       (in_ch.value),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .is_new      (out_ch.is_new),
    .found_slot  (out_ch.found_slot),
    .attr_value  (out_ch.attr_value),
    .stored_key  (out_ch.stored_key),
    .any_cyan    (out_ch.any_cyan),
    .occupied    (out_ch.occupied),
    .entry_count (out_ch.entry_count),
    .status      (out_ch.status)
  );

endmodule
